// File: sv/credential_table_link_checker_defines.svh
// assertion macros for the credential table link checker
`ifndef CREDENTIAL_TABLE_LINK_CHECKER_DEFINES_SVH
`define CREDENTIAL_TABLE_LINK_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS
`define CTLC_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CTLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CTLC_ASSERT(label, ante, cons, msg)
`define CTLC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: sv/ctlc_pkg.sv
// shared types and constants of the credential table link checker
package ctlc_pkg;

    localparam int NUM_SLOTS_DEF = 32;
    localparam int KEY_BYTES_DEF = 8;

    localparam int OP_W        = 2;
    localparam int BYTE_W      = 8;
    localparam int KEY_IN_W    = 64;
    localparam int KIND_W      = 2;
    localparam int SLOT_OUT_W  = 5;
    localparam int COUNT_OUT_W = 6;
    localparam int BIDX_W      = 3;

    localparam logic [BYTE_W-1:0] HDR_ID    = 8'h55;
    localparam logic [BYTE_W-1:0] HDR_PASS  = 8'h66;
    localparam logic [BYTE_W-1:0] POLL_ID   = 8'h90;
    localparam logic [BYTE_W-1:0] POLL_PASS = 8'h80;

    typedef enum logic [OP_W-1:0] {
        OP_LINK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_EDIT   = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ID    = 2'd0,
        KIND_PASS  = 2'd1,
        KIND_ADMIN = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_ID   = 2'd1,
        MODE_PASS = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        JOB_ID_CHECK   = 3'd0,
        JOB_PASS_CHECK = 3'd1,
        JOB_ID_POLL    = 3'd2,
        JOB_PASS_POLL  = 3'd3,
        JOB_ADD        = 3'd4,
        JOB_EDIT       = 3'd5,
        JOB_DELETE     = 3'd6
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_RESP = 2'd2
    } state_t;

endpackage

// File: sv/credential_table_link_checker.sv
// credential table with link byte receiver, admin add/edit/delete and status replies
// One transaction is in work at a time. A link byte that only fills the receiver or
// sets its mode leaves the block idle for the next byte. A poll goes straight to the
// reply state without a scan. An admin operation or a completed ID or password walks
// the credential memory one slot per cycle through its single read port and ends
// early when the ID is found. Slot valid bits are flip-flops cleared by reset, so the
// table is usable right after reset with no clearing pass. A finished reply waits in
// the output register while the next transaction is taken. The input is stalled for
// as long as a poll, scan or reply is in work, and a reply that is ready before the
// previous one has left holds the block in its reply state until the output register
// frees up.
`include "credential_table_link_checker_defines.svh"

module credential_table_link_checker #(
    parameter int NUM_SLOTS = ctlc_pkg::NUM_SLOTS_DEF,
    parameter int KEY_BYTES = ctlc_pkg::KEY_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ctlc_pkg::OP_W-1:0]           operation,
    input  logic [ctlc_pkg::BYTE_W-1:0]         link_byte,
    input  logic [ctlc_pkg::KEY_IN_W-1:0]       user_id,
    input  logic [ctlc_pkg::KEY_IN_W-1:0]       password,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ctlc_pkg::KIND_W-1:0]         reply_kind,
    output logic                                ok,
    output logic [ctlc_pkg::SLOT_OUT_W-1:0]     slot,
    output logic [ctlc_pkg::COUNT_OUT_W-1:0]    user_count
);

    localparam int KEY_W  = 8 * KEY_BYTES;
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [ctlc_pkg::BIDX_W-1:0] LAST_BYTE = ctlc_pkg::BIDX_W'(KEY_BYTES - 1);

    ctlc_pkg::state_t state_reg, state_next;
    ctlc_pkg::mode_t  mode_reg, mode_next;
    ctlc_pkg::job_t   job_reg, job_next;
    ctlc_pkg::kind_t  kind_reg, kind_next;

    logic [ctlc_pkg::BIDX_W-1:0] bidx_reg, bidx_next;
    logic [KEY_W-1:0]            id_asm_reg, id_asm_next;
    logic [KEY_W-1:0]            pw_asm_reg, pw_asm_next;
    logic [KEY_W-1:0]            key_reg, key_next;
    logic [KEY_W-1:0]            new_pw_reg, new_pw_next;
    logic [KEY_W-1:0]            lane_word;
    logic                        last_id_reg, last_id_next;
    logic                        last_pw_reg, last_pw_next;
    logic [NUM_SLOTS-1:0]        valid_reg, valid_next;
    logic [CNT_W-1:0]            count_reg, count_next;

    logic [SLOT_W-1:0]           rd_idx_reg, rd_idx_next;
    logic [SLOT_W-1:0]           cmp_idx_reg;
    logic                        cmp_valid_reg, cmp_valid_next;
    logic                        hit_reg, hit_next;
    logic [SLOT_W-1:0]           hit_idx_reg, hit_idx_next;
    logic [KEY_W-1:0]            hit_pw_reg, hit_pw_next;
    logic                        free_reg, free_next;
    logic [SLOT_W-1:0]           free_idx_reg, free_idx_next;

    logic                                   out_valid_reg, out_valid_next;
    logic                                   ok_reg, ok_next;
    logic [ctlc_pkg::SLOT_OUT_W-1:0]        slot_out_reg, slot_out_next;
    logic [ctlc_pkg::COUNT_OUT_W-1:0]       count_out_reg, count_out_next;

    logic [2*KEY_W-1:0] mem [NUM_SLOTS];
    logic [2*KEY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;
    logic [2*KEY_W-1:0] mem_wdata;

    logic               in_accept;
    logic               out_take;
    logic               resp_go;
    logic               launch_scan;
    logic               launch_resp;
    logic [KEY_W-1:0]   rd_id;
    logic [KEY_W-1:0]   rd_pw;
    logic               cmp_hit;
    logic               scan_end;
    logic               pass_match;

    assign in_accept  = in_valid && (state_reg == ctlc_pkg::ST_IDLE);
    assign out_take   = out_valid_reg && !out_stall;
    assign resp_go    = (state_reg == ctlc_pkg::ST_RESP) && (!out_valid_reg || !out_stall);
    assign rd_id      = rd_data_reg[KEY_W-1:0];
    assign rd_pw      = rd_data_reg[2*KEY_W-1:KEY_W];
    assign cmp_hit    = cmp_valid_reg && valid_reg[cmp_idx_reg] && (rd_id == key_reg);
    assign scan_end   = cmp_valid_reg && (cmp_hit || (cmp_idx_reg == LAST_SLOT));
    assign pass_match = hit_reg && (hit_pw_reg == pw_asm_reg);

    // credential memory, id in the low half and password in the high half
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_idx_reg];
    end

    // transaction decode and link receiver
    always_comb
    begin
        mode_next   = mode_reg;
        bidx_next   = bidx_reg;
        id_asm_next = id_asm_reg;
        pw_asm_next = pw_asm_reg;
        job_next    = job_reg;
        key_next    = key_reg;
        new_pw_next = new_pw_reg;
        launch_scan = 1'b0;
        launch_resp = 1'b0;
        lane_word   = id_asm_reg;
        if (in_accept)
        begin
            unique case (ctlc_pkg::op_t'(operation))
                ctlc_pkg::OP_ADD:
                begin
                    job_next    = ctlc_pkg::JOB_ADD;
                    key_next    = user_id[KEY_W-1:0];
                    new_pw_next = password[KEY_W-1:0];
                    launch_scan = 1'b1;
                end
                ctlc_pkg::OP_EDIT:
                begin
                    job_next    = ctlc_pkg::JOB_EDIT;
                    key_next    = user_id[KEY_W-1:0];
                    new_pw_next = password[KEY_W-1:0];
                    launch_scan = 1'b1;
                end
                ctlc_pkg::OP_DELETE:
                begin
                    job_next    = ctlc_pkg::JOB_DELETE;
                    key_next    = user_id[KEY_W-1:0];
                    new_pw_next = password[KEY_W-1:0];
                    launch_scan = 1'b1;
                end
                ctlc_pkg::OP_LINK:
                begin
                    unique case (mode_reg)
                        ctlc_pkg::MODE_ID, ctlc_pkg::MODE_PASS:
                        begin
                            lane_word = (mode_reg == ctlc_pkg::MODE_ID) ? id_asm_reg : pw_asm_reg;
                            for (int l = 0; l < KEY_BYTES; l++)
                            begin
                                if (bidx_reg == ctlc_pkg::BIDX_W'(l))
                                begin
                                    lane_word[8*l +: 8] = link_byte;
                                end
                            end
                            if (mode_reg == ctlc_pkg::MODE_ID)
                            begin
                                id_asm_next = lane_word;
                            end
                            else
                            begin
                                pw_asm_next = lane_word;
                            end
                            if (bidx_reg == LAST_BYTE)
                            begin
                                bidx_next   = '0;
                                mode_next   = ctlc_pkg::MODE_IDLE;
                                launch_scan = 1'b1;
                                if (mode_reg == ctlc_pkg::MODE_ID)
                                begin
                                    key_next = lane_word;
                                    job_next = ctlc_pkg::JOB_ID_CHECK;
                                end
                                else
                                begin
                                    key_next = id_asm_reg;
                                    job_next = ctlc_pkg::JOB_PASS_CHECK;
                                end
                            end
                            else
                            begin
                                bidx_next = bidx_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            priority if (link_byte == ctlc_pkg::HDR_ID)
                            begin
                                mode_next = ctlc_pkg::MODE_ID;
                                bidx_next = '0;
                            end
                            else if (link_byte == ctlc_pkg::HDR_PASS)
                            begin
                                mode_next = ctlc_pkg::MODE_PASS;
                                bidx_next = '0;
                            end
                            else if (link_byte == ctlc_pkg::POLL_ID)
                            begin
                                job_next    = ctlc_pkg::JOB_ID_POLL;
                                launch_resp = 1'b1;
                            end
                            else if (link_byte == ctlc_pkg::POLL_PASS)
                            begin
                                job_next    = ctlc_pkg::JOB_PASS_POLL;
                                launch_resp = 1'b1;
                            end
                            else
                            begin
                                mode_next = mode_reg;
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    // slot scan, one memory read issued per cycle
    always_comb
    begin
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_pw_next    = hit_pw_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        if (launch_scan)
        begin
            rd_idx_next    = '0;
            cmp_valid_next = 1'b0;
            hit_next       = 1'b0;
            free_next      = 1'b0;
        end
        else if (state_reg == ctlc_pkg::ST_SCAN)
        begin
            if (scan_end)
            begin
                cmp_valid_next = 1'b0;
            end
            else
            begin
                cmp_valid_next = 1'b1;
                if (rd_idx_reg != LAST_SLOT)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            if (cmp_hit)
            begin
                hit_next     = 1'b1;
                hit_idx_next = cmp_idx_reg;
                hit_pw_next  = rd_pw;
            end
            if (cmp_valid_reg && !valid_reg[cmp_idx_reg] && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = cmp_idx_reg;
            end
        end
    end

    // reply and table update
    always_comb
    begin
        valid_next     = valid_reg;
        count_next     = count_reg;
        last_id_next   = last_id_reg;
        last_pw_next   = last_pw_reg;
        kind_next      = kind_reg;
        ok_next        = ok_reg;
        slot_out_next  = slot_out_reg;
        count_out_next = count_out_reg;
        out_valid_next = out_take ? 1'b0 : out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = hit_idx_reg;
        mem_wdata      = {new_pw_reg, key_reg};
        if (resp_go)
        begin
            out_valid_next = 1'b1;
            kind_next      = ctlc_pkg::KIND_ADMIN;
            ok_next        = 1'b0;
            slot_out_next  = '0;
            unique case (job_reg)
                ctlc_pkg::JOB_ID_CHECK:
                begin
                    kind_next    = ctlc_pkg::KIND_ID;
                    ok_next      = hit_reg;
                    last_id_next = hit_reg;
                    if (hit_reg)
                    begin
                        slot_out_next = ctlc_pkg::SLOT_OUT_W'(hit_idx_reg);
                    end
                end
                ctlc_pkg::JOB_PASS_CHECK:
                begin
                    kind_next    = ctlc_pkg::KIND_PASS;
                    ok_next      = pass_match;
                    last_pw_next = pass_match;
                    if (pass_match)
                    begin
                        slot_out_next = ctlc_pkg::SLOT_OUT_W'(hit_idx_reg);
                    end
                end
                ctlc_pkg::JOB_ID_POLL:
                begin
                    kind_next = ctlc_pkg::KIND_ID;
                    ok_next   = last_id_reg;
                end
                ctlc_pkg::JOB_PASS_POLL:
                begin
                    kind_next = ctlc_pkg::KIND_PASS;
                    ok_next   = last_pw_reg;
                end
                ctlc_pkg::JOB_ADD:
                begin
                    if (hit_reg)
                    begin
                        slot_out_next = ctlc_pkg::SLOT_OUT_W'(hit_idx_reg);
                    end
                    else if (free_reg)
                    begin
                        mem_we                  = 1'b1;
                        mem_waddr               = free_idx_reg;
                        valid_next[free_idx_reg] = 1'b1;
                        count_next              = CNT_W'(count_reg + 1'b1);
                        ok_next                 = 1'b1;
                        slot_out_next           = ctlc_pkg::SLOT_OUT_W'(free_idx_reg);
                    end
                end
                ctlc_pkg::JOB_EDIT:
                begin
                    if (hit_reg)
                    begin
                        mem_we        = 1'b1;
                        ok_next       = 1'b1;
                        slot_out_next = ctlc_pkg::SLOT_OUT_W'(hit_idx_reg);
                    end
                end
                ctlc_pkg::JOB_DELETE:
                begin
                    if (hit_reg)
                    begin
                        valid_next[hit_idx_reg] = 1'b0;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        ok_next       = 1'b1;
                        slot_out_next = ctlc_pkg::SLOT_OUT_W'(hit_idx_reg);
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
            count_out_next = ctlc_pkg::COUNT_OUT_W'(count_next);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ctlc_pkg::ST_IDLE:
            begin
                if (launch_scan)
                begin
                    state_next = ctlc_pkg::ST_SCAN;
                end
                else if (launch_resp)
                begin
                    state_next = ctlc_pkg::ST_RESP;
                end
            end
            ctlc_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ctlc_pkg::ST_RESP;
                end
            end
            ctlc_pkg::ST_RESP:
            begin
                if (resp_go)
                begin
                    state_next = ctlc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ctlc_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall   = (state_reg != ctlc_pkg::ST_IDLE);
        out_valid  = out_valid_reg;
        reply_kind = kind_reg;
        ok         = ok_reg;
        slot       = slot_out_reg;
        user_count = count_out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ctlc_pkg::ST_IDLE;
            mode_reg      <= ctlc_pkg::MODE_IDLE;
            bidx_reg      <= '0;
            id_asm_reg    <= '0;
            pw_asm_reg    <= '0;
            last_id_reg   <= 1'b0;
            last_pw_reg   <= 1'b0;
            valid_reg     <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            bidx_reg      <= bidx_next;
            id_asm_reg    <= id_asm_next;
            pw_asm_reg    <= pw_asm_next;
            last_id_reg   <= last_id_next;
            last_pw_reg   <= last_pw_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        key_reg       <= key_next;
        new_pw_reg    <= new_pw_next;
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= rd_idx_reg;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        hit_pw_reg    <= hit_pw_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        kind_reg      <= kind_next;
        ok_reg        <= ok_next;
        slot_out_reg  <= slot_out_next;
        count_out_reg <= count_out_next;
    end

    `CTLC_ASSERT(a_count_matches_valid, 1'b1, count_reg == CNT_W'($countones(valid_reg)), "user count differs from number of valid slots")
    `CTLC_ASSERT(a_reply_from_resp, $rose(out_valid_reg), $past(state_reg == ctlc_pkg::ST_RESP), "reply raised outside the reply state")
    `CTLC_ASSERT(a_write_in_resp, mem_we, resp_go && (job_reg == ctlc_pkg::JOB_ADD || job_reg == ctlc_pkg::JOB_EDIT), "memory write outside an admin reply")
    `CTLC_ASSERT_NEXT(a_admin_keeps_link, in_accept && (operation != ctlc_pkg::OP_LINK), (state_reg == ctlc_pkg::ST_SCAN) && (mode_reg == $past(mode_reg)) && (bidx_reg == $past(bidx_reg)), "admin transaction disturbed the link receiver")

endmodule
